// ===== hdl/matrix3_inverse_assert.svh =====
// ----------------------------------------------------------------------------
// matrix3_inverse_assert.svh
// Assertion macros used by the matrix inverse queue.
// ----------------------------------------------------------------------------
`ifndef MATRIX3_INVERSE_ASSERT_SVH
`define MATRIX3_INVERSE_ASSERT_SVH

// same-cycle implication, checked on every rising clk edge outside reset
`define MI3_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define MI3_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg
// Widths, index tables and types for the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
`default_nettype none

package mi3_pkg;

  localparam int ELEM_W = 32;               // element width
  localparam int FRAC_W = 28;               // fraction bits
  localparam int NELEM  = 9;

  // cofactor: difference of two element products
  localparam int CW     = 2 * ELEM_W + 1;
  // determinant: sum of three element-by-cofactor products
  localparam int DETW   = ELEM_W + CW + 2;
  // twice the scaled numerator magnitude, |c| << (2F+1)
  localparam int NW     = CW + 2 * FRAC_W + 1;
  // rounding quotient width (one guard bit), plus an overflow bit
  localparam int QW     = ELEM_W + 1;
  localparam int KW     = QW + 1;
  // remainder width: holds the numerator and the divisor at its top shift
  localparam int RW     = (NW > DETW + QW) ? NW : DETW + QW;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = QAW + 1;

  // cofactor k = a[X]*a[Y] - a[Z]*a[V], row-major element index
  localparam int CF_X [NELEM] = '{4, 5, 3, 7, 8, 6, 1, 2, 0};
  localparam int CF_Y [NELEM] = '{8, 6, 7, 2, 0, 1, 5, 3, 4};
  localparam int CF_Z [NELEM] = '{5, 3, 4, 8, 6, 7, 2, 0, 1};
  localparam int CF_V [NELEM] = '{7, 8, 6, 1, 2, 0, 4, 5, 3};

  // output element i takes the transposed cofactor
  localparam int TR [NELEM] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

  typedef logic [NELEM-1:0][ELEM_W-1:0] mat_t;
  typedef logic [NELEM-1:0][CW-1:0]     cof_t;

  // one beat handed from the front to the back
  typedef struct packed {
    mat_t             a;
    cof_t             c;
    logic [DETW-1:0]  det;
  } qent_t;

endpackage

`default_nettype wire

// ===== hdl/mi3_front.sv =====
// ----------------------------------------------------------------------------
// mi3_front
// Accepts a matrix and forms its nine cofactors and its determinant.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mi3_pkg::mat_t a_in,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mi3_pkg::qent_t     out_ent
);

  logic en;
  logic v1, v2, v3, v4;

  logic signed [2*mi3_pkg::ELEM_W-1:0] px1 [mi3_pkg::NELEM];
  logic signed [2*mi3_pkg::ELEM_W-1:0] py1 [mi3_pkg::NELEM];
  mi3_pkg::mat_t a1, a2, a3, a4;
  mi3_pkg::cof_t c2, c3, c4;
  logic signed [2*mi3_pkg::ELEM_W:0] plo3 [3];
  logic signed [2*mi3_pkg::ELEM_W:0] phi3 [3];
  logic signed [mi3_pkg::DETW-1:0] det4;

  // whole pipe holds while the last stage waits on the queue
  assign en       = !v4 || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // stage 1: the eighteen element products
  // stage 2: cofactor differences
  for (genvar k = 0; k < mi3_pkg::NELEM; k++) begin : g_cof
    always_ff @(posedge clk) begin
      if (en) begin
        px1[k] <= $signed(a_in[mi3_pkg::CF_X[k]]) * $signed(a_in[mi3_pkg::CF_Y[k]]);
        py1[k] <= $signed(a_in[mi3_pkg::CF_Z[k]]) * $signed(a_in[mi3_pkg::CF_V[k]]);
        c2[k]  <= mi3_pkg::CW'(px1[k]) - mi3_pkg::CW'(py1[k]);
      end
    end
  end

  // stage 3: column-0 expansion, each product cut in two halves
  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk) begin
      if (en) begin
        plo3[j] <= $signed(a2[3*j]) * $signed({1'b0, c2[3*j][mi3_pkg::ELEM_W-1:0]});
        phi3[j] <= $signed(a2[3*j]) *
                   $signed(c2[3*j][mi3_pkg::CW-1:mi3_pkg::ELEM_W]);
      end
    end
  end

  // stage 4: sum of partials; element and cofactor copies ride along
  always_ff @(posedge clk) begin
    if (en) begin
      a1   <= a_in;
      a2   <= a1;
      a3   <= a2;
      a4   <= a3;
      c3   <= c2;
      c4   <= c3;
      det4 <= (mi3_pkg::DETW'(phi3[0]) <<< mi3_pkg::ELEM_W) + mi3_pkg::DETW'(plo3[0]) +
              (mi3_pkg::DETW'(phi3[1]) <<< mi3_pkg::ELEM_W) + mi3_pkg::DETW'(plo3[1]) +
              (mi3_pkg::DETW'(phi3[2]) <<< mi3_pkg::ELEM_W) + mi3_pkg::DETW'(plo3[2]);
    end
  end

  assign out_valid   = v4;
  assign out_ent.a   = a4;
  assign out_ent.c   = c4;
  assign out_ent.det = det4;

endmodule

`default_nettype wire

// ===== hdl/mi3_queue.sv =====
// ----------------------------------------------------------------------------
// mi3_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "matrix3_inverse_assert.svh"

module mi3_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire mi3_pkg::qent_t in_ent,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mi3_pkg::qent_t      out_ent
);

  mi3_pkg::qent_t            mem [mi3_pkg::QDEPTH];
  logic [mi3_pkg::QAW-1:0]   wr_ptr, rd_ptr;
  logic [mi3_pkg::QCW-1:0]   count;
  logic                      push, pop;

  assign in_ready  = count != mi3_pkg::QCW'(mi3_pkg::QDEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_ent   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_ent;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == mi3_pkg::QAW'(mi3_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == mi3_pkg::QAW'(mi3_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `MI3_ASSERT_IMP(a_count_bound, 1'b1, count <= mi3_pkg::QCW'(mi3_pkg::QDEPTH), "queue over depth")
  `MI3_ASSERT_NXT(a_push_count, push && !pop, count == $past(count) + 1'b1, "push lost")
  `MI3_ASSERT_NXT(a_pop_count, pop && !push, count == $past(count) - 1'b1, "pop lost")

endmodule

`default_nettype wire

// ===== hdl/mi3_back.sv =====
// ----------------------------------------------------------------------------
// mi3_back
// Pipelined restoring division of each scaled cofactor by the determinant,
// rounding, clipping and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire mi3_pkg::qent_t in_ent,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mi3_pkg::mat_t       b,
  output logic                singular,
  output logic                saturated
);

  logic en;
  logic [mi3_pkg::KW:0] v;
  logic [mi3_pkg::KW:0] sing;
  logic [mi3_pkg::RW-1:0]    rem [mi3_pkg::KW+1][mi3_pkg::NELEM];
  logic [mi3_pkg::KW-1:0]    kq  [mi3_pkg::KW+1][mi3_pkg::NELEM];
  logic [mi3_pkg::NELEM-1:0] neg [mi3_pkg::KW+1];
  logic [mi3_pkg::DETW-1:0]  dm  [mi3_pkg::KW+1];
  mi3_pkg::mat_t             ap  [mi3_pkg::KW+1];

  logic                       dneg;
  logic [mi3_pkg::DETW-1:0]   dmag;
  logic [mi3_pkg::NELEM-1:0]  satl;
  mi3_pkg::mat_t              res;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[mi3_pkg::KW-1:0], in_valid};
      out_valid <= v[mi3_pkg::KW];
    end
  end

  // divisor magnitude
  assign dneg = in_ent.det[mi3_pkg::DETW-1];
  assign dmag = dneg ? -in_ent.det : in_ent.det;

  // stage 0: magnitudes and signs
  always_ff @(posedge clk) begin
    if (en) begin
      sing[0] <= in_ent.det == '0;
      dm[0]   <= dmag;
      ap[0]   <= in_ent.a;
    end
  end

  for (genvar l = 0; l < mi3_pkg::NELEM; l++) begin : g_lane
    logic                   cneg;
    logic [mi3_pkg::CW-1:0] cmag;
    logic [mi3_pkg::QW:0]   kr;
    logic [mi3_pkg::QW-1:0] q, lim, qc, val;

    assign cneg = in_ent.c[mi3_pkg::TR[l]][mi3_pkg::CW-1];
    assign cmag = cneg ? -in_ent.c[mi3_pkg::TR[l]] : in_ent.c[mi3_pkg::TR[l]];

    always_ff @(posedge clk) begin
      if (en) begin
        rem[0][l] <= mi3_pkg::RW'(cmag) << (2 * mi3_pkg::FRAC_W + 1);
        kq[0][l]  <= '0;
        neg[0][l] <= cneg ^ dneg;
      end
    end

    // one quotient bit per stage, top bit flags overflow
    for (genvar j = 0; j < mi3_pkg::KW; j++) begin : g_step
      logic [mi3_pkg::RW-1:0] dsh;
      logic                   ge;
      assign dsh = mi3_pkg::RW'(dm[j]) << (mi3_pkg::KW - 1 - j);
      assign ge  = rem[j][l] >= dsh;
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j+1][l] <= ge ? rem[j][l] - dsh : rem[j][l];
          kq[j+1][l]  <= kq[j][l] | (mi3_pkg::KW'(ge) << (mi3_pkg::KW - 1 - j));
          neg[j+1][l] <= neg[j][l];
        end
      end
    end

    // round half away from zero, clip, apply sign
    always_comb begin
      kr   = {1'b0, kq[mi3_pkg::KW][l][mi3_pkg::QW-1:0]} + 1'b1;
      q    = kr[mi3_pkg::QW:1];
      lim  = neg[mi3_pkg::KW][l] ? (mi3_pkg::QW'(1) << (mi3_pkg::ELEM_W - 1))
                                 : (mi3_pkg::QW'(1) << (mi3_pkg::ELEM_W - 1)) - 1'b1;
      satl[l] = kq[mi3_pkg::KW][l][mi3_pkg::KW-1] || (q > lim);
      qc   = satl[l] ? lim : q;
      val  = neg[mi3_pkg::KW][l] ? -qc : qc;
      res[l] = val[mi3_pkg::ELEM_W-1:0];
    end
  end

  // side data through the divider stages
  for (genvar j = 0; j < mi3_pkg::KW; j++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        sing[j+1] <= sing[j];
        dm[j+1]   <= dm[j];
        ap[j+1]   <= ap[j];
      end
    end
  end

  // output register; a singular matrix passes through unchanged
  always_ff @(posedge clk) begin
    if (en) begin
      b         <= sing[mi3_pkg::KW] ? ap[mi3_pkg::KW] : res;
      singular  <= sing[mi3_pkg::KW];
      saturated <= !sing[mi3_pkg::KW] && (|satl);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/matrix3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse
// Inverse of a 3x3 signed Q4.28 matrix by cofactors and one division per
// element.
// ----------------------------------------------------------------------------
// Takes one matrix per clock and returns one inverse per clock when the
// output side keeps up. The path runs through four front stages (products,
// cofactors, determinant partials, determinant sum), the queue, then one
// magnitude stage, 34 divider stages that each settle one quotient bit per
// element, and the output register. The divider depth is the element width
// plus two. A singular matrix comes back unchanged with singular set;
// clipped results set saturated. Input and output stall independently
// through a four-beat queue between the halves.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix3_inverse (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [mi3_pkg::ELEM_W-1:0]  a00,
  input  wire logic [mi3_pkg::ELEM_W-1:0]  a01,
  input  wire logic [mi3_pkg::ELEM_W-1:0]  a02,
  input  wire logic [mi3_pkg::ELEM_W-1:0]  a10,
  input  wire logic [mi3_pkg::ELEM_W-1:0]  a11,
  input  wire logic [mi3_pkg::ELEM_W-1:0]  a12,
  input  wire logic [mi3_pkg::ELEM_W-1:0]  a20,
  input  wire logic [mi3_pkg::ELEM_W-1:0]  a21,
  input  wire logic [mi3_pkg::ELEM_W-1:0]  a22,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [mi3_pkg::ELEM_W-1:0]       b00,
  output logic [mi3_pkg::ELEM_W-1:0]       b01,
  output logic [mi3_pkg::ELEM_W-1:0]       b02,
  output logic [mi3_pkg::ELEM_W-1:0]       b10,
  output logic [mi3_pkg::ELEM_W-1:0]       b11,
  output logic [mi3_pkg::ELEM_W-1:0]       b12,
  output logic [mi3_pkg::ELEM_W-1:0]       b20,
  output logic [mi3_pkg::ELEM_W-1:0]       b21,
  output logic [mi3_pkg::ELEM_W-1:0]       b22,
  output logic                             singular,
  output logic                             saturated
);

  mi3_pkg::mat_t  a_in, b;
  mi3_pkg::qent_t f_ent, q_ent;
  logic           f_valid, f_ready, q_valid, q_ready;

  assign a_in = {a22, a21, a20, a12, a11, a10, a02, a01, a00};

  mi3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .a_in      (a_in),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_ent   (f_ent)
  );

  mi3_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_ent    (f_ent),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_ent   (q_ent)
  );

  mi3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_ent    (q_ent),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .b         (b),
    .singular  (singular),
    .saturated (saturated)
  );

  assign b00 = b[0];
  assign b01 = b[1];
  assign b02 = b[2];
  assign b10 = b[3];
  assign b11 = b[4];
  assign b12 = b[5];
  assign b20 = b[6];
  assign b21 = b[7];
  assign b22 = b[8];

endmodule

`default_nettype wire
